@@ sv/eqct_pkg.sv @@
`timescale 1ns / 1ps
package eqct_pkg;

    localparam int MAX_KEYS = 64;
    localparam int KEY_W    = 6;
    localparam int LABEL_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int OP_W     = 2;
    localparam int IDX_W    = $clog2(MAX_KEYS);

    localparam logic [KEY_W:0]   KEY_LIMIT = (KEY_W + 1)'(MAX_KEYS);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_KEYS - 1);

    // Stream packing.
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 2;
    localparam int OP_LSB      = 0;
    localparam int KA_LSB      = OP_LSB + OP_W;
    localparam int KB_LSB      = KA_LSB + KEY_W;
    localparam int MEM_LSB     = LABEL_W;

    localparam logic [OP_W-1:0] OP_LINK  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_LIST  = 2'd2;

    // Kinds of result written into the output register.
    localparam logic [2:0] EMIT_NONE   = 3'd0;
    localparam logic [2:0] EMIT_QUERY  = 3'd1;
    localparam logic [2:0] EMIT_LINK   = 3'd2;
    localparam logic [2:0] EMIT_ERR    = 3'd3;
    localparam logic [2:0] EMIT_MEMBER = 3'd4;
    localparam logic [2:0] EMIT_FINAL  = 3'd5;

    // Label RAM read address source.
    localparam logic [1:0] RD_IN   = 2'd0;
    localparam logic [1:0] RD_B    = 2'd1;
    localparam logic [1:0] RD_SCAN = 2'd2;

    typedef struct packed {
        logic             load;
        logic [1:0]       rd_sel;
        logic [IDX_W-1:0] scan_rd;
        logic [IDX_W-1:0] scan_idx;
        logic             cap_a;
        logic             cap_b;
        logic             link_apply;
        logic             link_b_wr;
        logic             merge_wr;
        logic             list_clear;
        logic             list_step;
        logic             cnt_dec;
        logic [2:0]       emit;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            ok_link;
        logic            va_ok;
        logic            vb_ok;
        logic            la_eq_lb;
        logic            match;
        logic            pend_v;
        logic            out_free;
    } t_dp_sts;

endpackage

@@ sv/equivalence_class_table.sv @@
`timescale 1ns / 1ps
// Equivalence class table over keys 0..MAX_KEYS-1: each key holds a dense class label in a
// single-port-read label RAM, with per-key valid bits in flip-flops. One command is worked at a
// time: key_a's label is read, then key_b's, then the command is decided. A link that starts a
// new class writes key_b's label in a state of its own after that. A merge or a list sweeps the
// label RAM one key per cycle; any result waits while the output register is still held, and a
// list stalls once for each member that waits there until it is taken. The input is ready only
// between commands.
module equivalence_class_table
    import eqct_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // opcode [1:0], key_a [7:2], key_b [13:8], zero [15:14]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // class_index [5:0], member [11:6], zero [15:12]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    // found [0], error [1]
    output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    eqct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tvalid (s_axis_tvalid),
        .o_in_tready (s_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    eqct_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_in_tdata   (s_axis_tdata),
        .i_out_tready (m_axis_tready),
        .o_out_tvalid (m_axis_tvalid),
        .o_out_tdata  (m_axis_tdata),
        .o_out_tlast  (m_axis_tlast),
        .o_out_tuser  (m_axis_tuser)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again before the previous command finished");

    a_emit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit != EMIT_NONE |-> w_sts.out_free)
        else $error("result written over one not yet transferred");

    a_single_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.link_apply, w_cmd.link_b_wr, w_cmd.merge_wr}))
        else $error("more than one label write source active");

endmodule

@@ sv/eqct_ram.sv @@
`timescale 1ns / 1ps
module eqct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/eqct_datapath.sv @@
`timescale 1ns / 1ps
module eqct_datapath
    import eqct_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  logic [IN_TDATA_W-1:0]  i_in_tdata,
    input  logic                   i_out_tready,
    output logic                   o_out_tvalid,
    output logic [OUT_TDATA_W-1:0] o_out_tdata,
    output logic                   o_out_tlast,
    output logic [OUT_TUSER_W-1:0] o_out_tuser
);

    logic [OP_W-1:0]    r_op;
    logic [KEY_W-1:0]   r_a;
    logic [KEY_W-1:0]   r_b;
    logic [LABEL_W-1:0] r_la;
    logic [LABEL_W-1:0] r_lb;
    logic [LABEL_W-1:0] r_cls;
    logic [COUNT_W-1:0] r_count;
    logic [MAX_KEYS-1:0] r_valid;
    logic [IDX_W-1:0]   r_pend;
    logic               r_pend_v;

    logic               r_ovalid;
    logic [LABEL_W-1:0] r_ocls;
    logic               r_ofound;
    logic [KEY_W-1:0]   r_omember;
    logic               r_olast;
    logic               r_oerr;

    logic [IDX_W-1:0]   a_idx;
    logic [IDX_W-1:0]   b_idx;
    logic               ok_a;
    logic               ok_b;
    logic               va;
    logic               vb;
    logic [LABEL_W-1:0] q;
    logic [IDX_W-1:0]   raddr;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [LABEL_W-1:0] wdata;
    logic [LABEL_W-1:0] keep;
    logic [LABEL_W-1:0] gone;
    logic [LABEL_W-1:0] relabel;
    logic [LABEL_W-1:0] link_cls;
    logic               out_free;

    assign a_idx = r_a[IDX_W-1:0];
    assign b_idx = r_b[IDX_W-1:0];
    assign ok_a  = {1'b0, r_a} < KEY_LIMIT;
    assign ok_b  = {1'b0, r_b} < KEY_LIMIT;
    assign va    = ok_a && r_valid[a_idx];
    assign vb    = ok_b && r_valid[b_idx];

    assign keep = (r_la < r_lb) ? r_la : r_lb;
    assign gone = (r_la < r_lb) ? r_lb : r_la;

    // Renumbering of one label during a merge sweep.
    always_comb begin
        if (q == gone) begin
            relabel = keep;
        end else if (q > gone) begin
            relabel = q - LABEL_W'(1);
        end else begin
            relabel = q;
        end
    end

    always_comb begin
        if (va && vb) begin
            link_cls = keep;
        end else if (va) begin
            link_cls = r_la;
        end else if (vb) begin
            link_cls = r_lb;
        end else begin
            link_cls = r_count[LABEL_W-1:0];
        end
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_IN:   raddr = i_in_tdata[KA_LSB +: IDX_W];
            RD_B:    raddr = b_idx;
            default: raddr = i_cmd.scan_rd;
        endcase
    end

    always_comb begin
        we    = 1'b0;
        waddr = i_cmd.scan_idx;
        wdata = relabel;
        if (i_cmd.link_apply) begin
            if (va && !vb) begin
                we    = 1'b1;
                waddr = b_idx;
                wdata = r_la;
            end else if (!va && vb) begin
                we    = 1'b1;
                waddr = a_idx;
                wdata = r_lb;
            end else if (!va && !vb) begin
                we    = 1'b1;
                waddr = a_idx;
                wdata = r_count[LABEL_W-1:0];
            end
        end else if (i_cmd.link_b_wr) begin
            we    = 1'b1;
            waddr = b_idx;
            wdata = r_cls;
        end else if (i_cmd.merge_wr) begin
            we = r_valid[i_cmd.scan_idx];
        end
    end

    eqct_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (MAX_KEYS)
    ) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_in_tdata[OP_LSB +: OP_W];
            r_a  <= i_in_tdata[KA_LSB +: KEY_W];
            r_b  <= i_in_tdata[KB_LSB +: KEY_W];
        end
        if (i_cmd.cap_a) begin
            r_la <= q;
        end
        if (i_cmd.cap_b) begin
            r_lb <= q;
        end
        if (i_cmd.link_apply) begin
            r_cls <= link_cls;
        end
        if (i_cmd.list_step) begin
            r_pend <= i_cmd.scan_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_count  <= '0;
            r_pend_v <= 1'b0;
        end else begin
            if (i_cmd.link_apply) begin
                if (!va) begin
                    r_valid[a_idx] <= 1'b1;
                end
                if (!vb) begin
                    r_valid[b_idx] <= 1'b1;
                end
                if (!va && !vb) begin
                    r_count <= r_count + COUNT_W'(1);
                end
            end else if (i_cmd.cnt_dec && r_count != '0) begin
                r_count <= r_count - COUNT_W'(1);
            end
            if (i_cmd.list_clear) begin
                r_pend_v <= 1'b0;
            end else if (i_cmd.list_step) begin
                r_pend_v <= 1'b1;
            end
        end
    end

    assign out_free = !r_ovalid || i_out_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit != EMIT_NONE) begin
            r_ovalid <= 1'b1;
        end else if (i_out_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.emit)
            EMIT_QUERY: begin
                r_ocls    <= va ? r_la : '0;
                r_ofound  <= va;
                r_omember <= '0;
                r_olast   <= 1'b1;
                r_oerr    <= 1'b0;
            end
            EMIT_LINK: begin
                r_ocls    <= link_cls;
                r_ofound  <= 1'b1;
                r_omember <= '0;
                r_olast   <= 1'b1;
                r_oerr    <= 1'b0;
            end
            EMIT_ERR: begin
                r_ocls    <= '0;
                r_ofound  <= 1'b0;
                r_omember <= '0;
                r_olast   <= 1'b1;
                r_oerr    <= 1'b1;
            end
            EMIT_MEMBER, EMIT_FINAL: begin
                r_ocls    <= r_la;
                r_ofound  <= 1'b1;
                r_omember <= KEY_W'(r_pend);
                r_olast   <= (i_cmd.emit == EMIT_FINAL);
                r_oerr    <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_out_tvalid = r_ovalid;
    assign o_out_tdata  = {{(OUT_TDATA_W - MEM_LSB - KEY_W){1'b0}}, r_omember, r_ocls};
    assign o_out_tlast  = r_olast;
    assign o_out_tuser  = {r_oerr, r_ofound};

    assign o_sts.op       = r_op;
    assign o_sts.ok_link  = ok_a && ok_b;
    assign o_sts.va_ok    = va;
    assign o_sts.vb_ok    = vb;
    assign o_sts.la_eq_lb = (r_la == r_lb);
    assign o_sts.match    = r_valid[i_cmd.scan_idx] && (q == r_la);
    assign o_sts.pend_v   = r_pend_v;
    assign o_sts.out_free = out_free;

endmodule

@@ sv/eqct_ctrl.sv @@
`timescale 1ns / 1ps
module eqct_ctrl
    import eqct_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_tvalid,
    output logic    o_in_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RDA   = 3'd1;
    localparam logic [2:0] S_RDB   = 3'd2;
    localparam logic [2:0] S_DEC   = 3'd3;
    localparam logic [2:0] S_LINK2 = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [IDX_W-1:0] r_ridx;
    logic [IDX_W-1:0] n_ridx;
    logic             advance;

    always_comb begin
        o_cmd          = '0;
        o_cmd.rd_sel   = RD_SCAN;
        o_cmd.scan_rd  = r_ridx;
        o_cmd.scan_idx = r_ridx;
        o_cmd.emit     = EMIT_NONE;
        n_state        = r_state;
        n_ridx         = r_ridx;
        advance        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_cmd.rd_sel = RD_IN;
                if (i_in_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RDA;
                end
            end
            S_RDA: begin
                o_cmd.cap_a  = 1'b1;
                o_cmd.rd_sel = RD_B;
                n_state      = S_RDB;
            end
            S_RDB: begin
                o_cmd.cap_b = 1'b1;
                n_state     = S_DEC;
            end
            S_DEC: begin
                case (i_sts.op)
                    OP_LINK: begin
                        if (!i_sts.ok_link) begin
                            if (i_sts.out_free) begin
                                o_cmd.emit = EMIT_ERR;
                                n_state    = S_IDLE;
                            end
                        end else if (i_sts.va_ok && i_sts.vb_ok && !i_sts.la_eq_lb) begin
                            o_cmd.scan_rd = '0;
                            n_ridx        = '0;
                            n_state       = S_SCAN;
                        end else if (i_sts.out_free) begin
                            o_cmd.link_apply = 1'b1;
                            o_cmd.emit       = EMIT_LINK;
                            // A fresh class needs a second label write for key_b.
                            n_state = (!i_sts.va_ok && !i_sts.vb_ok) ? S_LINK2 : S_IDLE;
                        end
                    end
                    OP_QUERY: begin
                        if (i_sts.out_free) begin
                            o_cmd.emit = EMIT_QUERY;
                            n_state    = S_IDLE;
                        end
                    end
                    OP_LIST: begin
                        if (!i_sts.va_ok) begin
                            if (i_sts.out_free) begin
                                o_cmd.emit = EMIT_ERR;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            o_cmd.list_clear = 1'b1;
                            o_cmd.scan_rd    = '0;
                            n_ridx           = '0;
                            n_state          = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_LINK2: begin
                o_cmd.link_b_wr = 1'b1;
                n_state         = S_IDLE;
            end
            S_SCAN: begin
                if (i_sts.op == OP_LINK) begin
                    o_cmd.merge_wr = 1'b1;
                    advance        = 1'b1;
                end else if (i_sts.match) begin
                    // A member is held back one step so that the final one can carry last.
                    if (!i_sts.pend_v) begin
                        o_cmd.list_step = 1'b1;
                        advance         = 1'b1;
                    end else if (i_sts.out_free) begin
                        o_cmd.emit      = EMIT_MEMBER;
                        o_cmd.list_step = 1'b1;
                        advance         = 1'b1;
                    end
                end else begin
                    advance = 1'b1;
                end
                if (advance) begin
                    if (r_ridx == LAST_IDX) begin
                        n_state = S_FIN;
                    end else begin
                        n_ridx        = r_ridx + IDX_W'(1);
                        o_cmd.scan_rd = r_ridx + IDX_W'(1);
                    end
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = (i_sts.op == OP_LINK) ? EMIT_LINK : EMIT_FINAL;
                    o_cmd.cnt_dec = (i_sts.op == OP_LINK);
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ridx  <= '0;
        end else begin
            r_state <= n_state;
            r_ridx  <= n_ridx;
        end
    end

    assign o_in_tready = (r_state == S_IDLE);

endmodule

@@ test/equivalence_class_table_tb.sv @@
`timescale 1ns / 1ps
module equivalence_class_table_tb;
    import eqct_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 228;
    localparam int SINK_HOLD    = 300;

    typedef struct packed {
        logic [LABEL_W-1:0] class_index;
        logic               found;
        logic [KEY_W-1:0]   member;
        logic               last;
        logic               error;
    } t_result;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_b;
        logic             typed;
        t_result          want;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // opcode [1:0], key_a [7:2], key_b [13:8], zero [15:14]
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // class_index [5:0], member [11:6], zero [15:12]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    // found [0], error [1]
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    // Shadow of the label table, starting from its reset state.
    bit                 key_in_class [MAX_KEYS] = '{default: 1'b0};
    logic [LABEL_W-1:0] key_class [MAX_KEYS] = '{default: '0};
    logic [COUNT_W-1:0] class_total = '0;

    t_result   due_results[$];
    t_stim_row directed[$];
    int        mismatch_count = 0;
    int        quiet_cycles = 0;
    bit        calm_phase = 1'b0;
    bit        sink_hold_req = 1'b0;

    equivalence_class_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_result result_of(input int cls, input int found, input int member,
                                          input int last, input int error);
        t_result r;
        r.class_index = LABEL_W'(cls);
        r.found       = found[0];
        r.member      = KEY_W'(member);
        r.last        = last[0];
        r.error       = error[0];
        return r;
    endfunction

    function automatic t_stim_row row(input logic [OP_W-1:0] op, input int a, input int b,
                                      input bit typed = 1'b0, input t_result want = '0);
        t_stim_row s;
        s.op    = op;
        s.key_a = KEY_W'(a);
        s.key_b = KEY_W'(b);
        s.typed = typed;
        s.want  = want;
        return s;
    endfunction

    task automatic add_row(input t_stim_row s);
        directed = {directed, s};
    endtask

    task automatic queue_due(input t_result r, input bit record);
        if (record)
            due_results = {due_results, r};
    endtask

    task automatic note_mismatch(input string what);
        $display("[eqct] t=%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Updates the shadow table for one command and, when asked, queues the results it causes.
    task automatic apply_command(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] a,
                                 input logic [KEY_W-1:0] b, input bit record);
        logic [LABEL_W-1:0] keep, gone, lab;
        int members, emitted;
        bit a_ok, b_ok;
        a_ok = int'(a) < MAX_KEYS;
        b_ok = int'(b) < MAX_KEYS;
        case (op)
            OP_LINK: begin
                if (!a_ok || !b_ok) begin
                    queue_due(result_of(0, 0, 0, 1, 1), record);
                end else begin
                    if (key_in_class[a] && key_in_class[b]) begin
                        if (key_class[a] != key_class[b]) begin
                            // The lower label survives; labels above the removed one close the gap.
                            keep = (key_class[a] < key_class[b]) ? key_class[a] : key_class[b];
                            gone = (key_class[a] < key_class[b]) ? key_class[b] : key_class[a];
                            for (int k = 0; k < MAX_KEYS; k++) begin
                                if (key_in_class[k]) begin
                                    if (key_class[k] == gone)
                                        key_class[k] = keep;
                                    else if (key_class[k] > gone)
                                        key_class[k] = key_class[k] - 1'b1;
                                end
                            end
                            if (class_total != 0)
                                class_total = class_total - 1'b1;
                        end
                    end else if (key_in_class[a]) begin
                        key_in_class[b] = 1'b1;
                        key_class[b]    = key_class[a];
                    end else if (key_in_class[b]) begin
                        key_in_class[a] = 1'b1;
                        key_class[a]    = key_class[b];
                    end else begin
                        key_in_class[a] = 1'b1;
                        key_class[a]    = class_total[LABEL_W-1:0];
                        key_in_class[b] = 1'b1;
                        key_class[b]    = class_total[LABEL_W-1:0];
                        class_total     = class_total + 1'b1;
                    end
                    queue_due(result_of(key_class[a], 1, 0, 1, 0), record);
                end
            end
            OP_QUERY: begin
                if (a_ok && key_in_class[a])
                    queue_due(result_of(key_class[a], 1, 0, 1, 0), record);
                else
                    queue_due(result_of(0, 0, 0, 1, 0), record);
            end
            OP_LIST: begin
                if (!(a_ok && key_in_class[a])) begin
                    queue_due(result_of(0, 0, 0, 1, 1), record);
                end else begin
                    lab = key_class[a];
                    members = 0;
                    for (int k = 0; k < MAX_KEYS; k++)
                        if (key_in_class[k] && key_class[k] == lab)
                            members++;
                    emitted = 0;
                    for (int k = 0; k < MAX_KEYS; k++) begin
                        if (key_in_class[k] && key_class[k] == lab) begin
                            emitted++;
                            queue_due(result_of(lab, 1, k, emitted == members, 0), record);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Offers one command, with an occasional gap first, and returns once it has been taken.
    task automatic send_command(input t_stim_row s);
        int gap;
        gap = 0;
        if (!calm_phase && $urandom_range(0, 99) < 21)
            gap = $urandom_range(1, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, s.key_b, s.key_a, s.op};
        do @(posedge i_clk); while (!s_axis_tready);
        apply_command(s.op, s.key_a, s.key_b, !s.typed);
        if (s.typed)
            queue_due(s.want, 1'b1);
    endtask

    task automatic check_field(input string name, input int got, input int due);
        if (got != due)
            note_mismatch($sformatf("%s is %0d, expected %0d", name, got, due));
    endtask

    always @(posedge i_clk) begin : result_check
        t_result got, due;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.class_index = m_axis_tdata[LABEL_W-1:0];
            got.member      = m_axis_tdata[MEM_LSB +: KEY_W];
            got.last        = m_axis_tlast;
            got.found       = m_axis_tuser[0];
            got.error       = m_axis_tuser[1];
            if (due_results.size() == 0) begin
                note_mismatch($sformatf("result with none expected: %p", got));
            end else begin
                due = due_results.pop_front();
                check_field("class_index", got.class_index, due.class_index);
                check_field("found", got.found, due.found);
                check_field("member", got.member, due.member);
                check_field("last", got.last, due.last);
                check_field("error", got.error, due.error);
            end
        end
    end

    // Result side: random back-pressure, a calm stretch, and one long hold-off on request.
    initial begin : sink_ctrl
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req && !hold_done) begin
                hold_left = SINK_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (calm_phase) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= 21);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("equivalence_class_table: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        int counted;
        t_stim_row s;
        add_row(row(OP_QUERY, 0, 0, 1, result_of(0, 0, 0, 1, 0)));
        add_row(row(OP_LIST, 63, 63, 1, result_of(0, 0, 0, 1, 1)));
        add_row(row(OP_SPARE, 0, 0));
        add_row(row(OP_LINK, 0, 0, 1, result_of(0, 1, 0, 1, 0)));
        add_row(row(OP_LINK, 63, 63, 1, result_of(1, 1, 0, 1, 0)));
        add_row(row(OP_LINK, 1, 62, 1, result_of(2, 1, 0, 1, 0)));
        add_row(row(OP_QUERY, 63, 0, 1, result_of(1, 1, 0, 1, 0)));
        add_row(row(OP_LINK, 62, 0));   // merge with the first class the higher
        add_row(row(OP_LIST, 62, 0));
        add_row(row(OP_LINK, 5, 63));   // first key joins the second key's class
        add_row(row(OP_LINK, 63, 6));   // second key joins the first key's class
        add_row(row(OP_LINK, 63, 1));   // merge with the first class the higher
        add_row(row(OP_LIST, 0, 0));
        add_row(row(OP_LINK, 0, 63));   // already together
        add_row(row(OP_LINK, 10, 11));
        add_row(row(OP_LINK, 12, 13));
        add_row(row(OP_LINK, 20, 21));
        add_row(row(OP_LINK, 13, 20));  // merge of two classes above the lowest
        add_row(row(OP_LINK, 11, 12));
        add_row(row(OP_QUERY, 21, 0));
        add_row(row(OP_LIST, 10, 0));
        add_row(row(OP_SPARE, 63, 63));
        add_row(row(OP_QUERY, 42, 21, 1, result_of(0, 0, 0, 1, 0)));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i])
            send_command(directed[i]);

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            calm_phase = (counted >= 40 && counted < 100);
            if (counted == 120)
                sink_hold_req = 1'b1;
            if (counted == 180) begin
                // Let the block drain completely before carrying on.
                s_axis_tvalid <= 1'b0;
                while (due_results.size() != 0) @(posedge i_clk);
            end
            s = '0;
            case ($urandom_range(0, 99)) inside
                [0:39]:  s.op = OP_LINK;
                [40:59]: s.op = OP_QUERY;
                [60:89]: s.op = OP_LIST;
                default: s.op = OP_SPARE;
            endcase
            s.key_a = KEY_W'($urandom_range(0, MAX_KEYS - 1));
            // Nearby keys build chains of small classes, which keeps merges renumbering labels.
            if ($urandom_range(0, 99) < 70)
                s.key_b = s.key_a + KEY_W'($urandom_range(0, 3));
            else
                s.key_b = KEY_W'($urandom_range(0, MAX_KEYS - 1));
            send_command(s);
            counted++;
        end
        calm_phase = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (due_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", due_results.size()));

        if (mismatch_count == 0)
            $display("equivalence_class_table: match");
        else
            $display("equivalence_class_table: mismatch");
        $finish;
    end

endmodule
